>>> src/lig_pkg.sv
// Shared types and constants for the longest increasing grid path block.
`default_nettype none
package lig_pkg;

    localparam int CELL_W = 32;
    localparam int PATH_W = 13;
    localparam int CFG_W  = 7;

    // APB register map, byte addresses
    localparam logic [3:0] ADDR_ROWS = 4'h0;
    localparam logic [3:0] ADDR_COLS = 4'h4;
    localparam logic [3:0] ADDR_RUN  = 4'h8;

    // Neighbor direction codes
    localparam logic [2:0] DIR_UP    = 3'd0;
    localparam logic [2:0] DIR_DOWN  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_END   = 3'd4;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_CLEAR   = 9'b000000010,
        ST_SCAN    = 9'b000000100,
        ST_SCAN_W  = 9'b000001000,
        ST_EXPLORE = 9'b000010000,
        ST_EXP_W   = 9'b000100000,
        ST_FIN     = 9'b001000000,
        ST_POP_W   = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_wr;
        logic load_clr;
        logic sweep_clr;
        logic clr_step;
        logic scan_rd;
        logic scan_next;
        logic root;
        logic nb_rd;
        logic dir_inc;
        logic nb_eval;
        logic fin;
        logic pop;
        logic ans_clr;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic grid_ok;
        logic load_last;
        logic sweep_last;
        logic best_zero;
        logic dir_done;
        logic nb_valid;
        logic stack_empty;
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

>>> src/lig_if.sv
// Valid/ready channel interfaces for cell items and path length items.
`default_nettype none
interface lig_cell_if;
    import lig_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [CELL_W-1:0] cell_value;
    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface lig_path_if;
    import lig_pkg::*;
    logic              valid;
    logic              ready;
    logic [PATH_W-1:0] path_length;
    modport source (output valid, output path_length, input ready);
    modport sink   (input valid, input path_length, output ready);
endinterface
`default_nettype wire

>>> src/longest_increasing_grid_path_top.sv
// Top level: longest strictly increasing four-neighbor path over a loaded grid.
// Cells load at one item per cycle while the controller is idle, also while an earlier result still waits.
// With run_search set, the last cell starts a clear of all rows*cols best entries,
// then a sweep that reads cells, probes in-grid neighbors, skips off-grid ones,
// finishes cells and pops the stack; the result is registered, no input meanwhile.
// Reset (rst_n low, asynchronous) resets control, config, counter and search registers and output valid.
`default_nettype none
module longest_increasing_grid_path_top #(
    parameter int MAX_DIM = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    lig_cell_if.sink         in_ch,
    lig_path_if.source       out_ch
);
    import lig_pkg::*;

    logic [CFG_W-1:0] row_count_reg, col_count_reg;
    logic             run_search_reg;
    logic             wr_en, dim_wr, in_fire;
    cmd_t             cmd;
    status_t          status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign dim_wr = wr_en && ((paddr == ADDR_ROWS) || (paddr == ADDR_COLS));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= '0;
            col_count_reg  <= '0;
            run_search_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            case (paddr)
                ADDR_ROWS: row_count_reg  <= pwdata[CFG_W-1:0];
                ADDR_COLS: col_count_reg  <= pwdata[CFG_W-1:0];
                ADDR_RUN:  run_search_reg <= pwdata[0];
                default:   ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr)
            ADDR_ROWS: prdata = 32'(row_count_reg);
            ADDR_COLS: prdata = 32'(col_count_reg);
            ADDR_RUN:  prdata = 32'(run_search_reg);
            default:   prdata = '0;
        endcase
    end

    assign in_fire = in_ch.valid && in_ch.ready;

    lig_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .run_search (run_search_reg),
        .status     (status),
        .cmd        (cmd),
        .in_ready   (in_ch.ready)
    );

    lig_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_count  (row_count_reg),
        .col_count  (col_count_reg),
        .cfg_dim_wr (dim_wr),
        .in_cell    (in_ch.cell_value),
        .cmd        (cmd),
        .out_ready  (out_ch.ready),
        .status     (status),
        .out_valid  (out_ch.valid),
        .out_path   (out_ch.path_length)
    );

endmodule
`default_nettype wire

>>> src/lig_ctrl.sv
// Sequencer for loading, best-depth clearing and depth-first search.
`default_nettype none
module lig_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic              run_search,
    input  wire lig_pkg::status_t  status,
    output lig_pkg::cmd_t          cmd,
    output logic                   in_ready
);
    import lig_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Cells are taken in idle, also while an earlier result waits
    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!status.grid_ok)
                    begin
                        cmd.load_clr = 1'b1;
                        if (run_search)
                        begin
                            cmd.ans_clr = 1'b1;
                            state_next  = ST_DONE;
                        end
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                        if (status.load_last && run_search)
                        begin
                            cmd.ans_clr   = 1'b1;
                            cmd.sweep_clr = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_W;
            end
            ST_SCAN_W:
            begin
                if (status.best_zero)
                begin
                    cmd.root   = 1'b1;
                    state_next = ST_EXPLORE;
                end
                else if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_EXPLORE:
            begin
                if (status.dir_done)
                begin
                    state_next = ST_FIN;
                end
                else if (status.nb_valid)
                begin
                    cmd.nb_rd  = 1'b1;
                    state_next = ST_EXP_W;
                end
                else
                begin
                    cmd.dir_inc = 1'b1;
                end
            end
            ST_EXP_W:
            begin
                cmd.nb_eval = 1'b1;
                state_next  = ST_EXPLORE;
            end
            ST_FIN:
            begin
                cmd.fin = 1'b1;
                if (!status.stack_empty)
                begin
                    state_next = ST_POP_W;
                end
                else if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_POP_W:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_EXPLORE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> src/lig_dp.sv
// Datapath: cell and best-depth memories, search stack, counters and result.
`default_nettype none
module lig_dp #(
    parameter int MAX_DIM = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [lig_pkg::CFG_W-1:0]     row_count,
    input  wire logic [lig_pkg::CFG_W-1:0]     col_count,
    input  wire logic                          cfg_dim_wr,
    input  wire logic signed [lig_pkg::CELL_W-1:0] in_cell,
    input  wire lig_pkg::cmd_t                 cmd,
    input  wire logic                          out_ready,
    output lig_pkg::status_t                   status,
    output logic                               out_valid,
    output logic [lig_pkg::PATH_W-1:0]         out_path
);
    import lig_pkg::*;

    localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW    = 2 * CW;
    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int LW    = AW + 1;
    localparam int SPW   = AW + 1;
    localparam int SEW   = 2 * CW + 3 + LW + CELL_W;

    logic signed [CELL_W-1:0] cell_mem  [CELLS];
    logic [LW-1:0]            best_mem  [CELLS];
    logic [SEW-1:0]           stack_mem [CELLS];

    logic [DW-1:0] rows_eff, cols_eff;
    logic [CW-1:0] ld_row_reg, ld_col_reg;
    logic [CW-1:0] sw_row_reg, sw_col_reg;
    logic [CW-1:0] cur_row_reg, cur_col_reg;
    logic [CW-1:0] nb_row_reg, nb_col_reg;
    logic [CW-1:0] nb_row, nb_col;
    logic          nb_valid;
    logic [2:0]    dir_reg;
    logic [LW-1:0] max_reg, d_reg, ans_reg;
    logic signed [CELL_W-1:0] cur_val_reg;
    logic [SPW-1:0] sp_reg;
    logic signed [CELL_W-1:0] cell_rd_reg;
    logic [LW-1:0]  best_rd_reg;
    logic [SEW-1:0] stack_rd_reg;
    logic [LW-1:0]  fin_depth;
    logic           ld_col_last, ld_row_last, sw_col_last, sw_row_last;
    logic           push;
    logic           out_valid_reg;
    logic [PATH_W-1:0] out_path_reg;
    logic [CW-1:0]  pop_row, pop_col;
    logic [2:0]     pop_dir;
    logic [LW-1:0]  pop_max;
    logic signed [CELL_W-1:0] pop_val;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
        logic [2*AW-1:0] prod;
        begin
            prod    = AW'(r) * AW'(MAX_DIM);
            addr_of = prod[AW-1:0] + AW'(c);
        end
    endfunction

    // Clamp dimensions to the grid capacity
    assign rows_eff = (int'(row_count) > MAX_DIM) ? DW'(MAX_DIM) : DW'(row_count);
    assign cols_eff = (int'(col_count) > MAX_DIM) ? DW'(MAX_DIM) : DW'(col_count);

    assign ld_col_last = (DW'(ld_col_reg) == cols_eff - DW'(1));
    assign ld_row_last = (DW'(ld_row_reg) == rows_eff - DW'(1));
    assign sw_col_last = (DW'(sw_col_reg) == cols_eff - DW'(1));
    assign sw_row_last = (DW'(sw_row_reg) == rows_eff - DW'(1));

    // Neighbor of the current cell in the current direction
    always_comb
    begin
        nb_row   = cur_row_reg;
        nb_col   = cur_col_reg;
        nb_valid = 1'b0;
        case (dir_reg)
            DIR_UP:
            begin
                nb_row   = cur_row_reg - CW'(1);
                nb_valid = (cur_row_reg != '0);
            end
            DIR_DOWN:
            begin
                nb_row   = cur_row_reg + CW'(1);
                nb_valid = (DW'(cur_row_reg) + DW'(1) < rows_eff);
            end
            DIR_LEFT:
            begin
                nb_col   = cur_col_reg - CW'(1);
                nb_valid = (cur_col_reg != '0);
            end
            DIR_RIGHT:
            begin
                nb_col   = cur_col_reg + CW'(1);
                nb_valid = (DW'(cur_col_reg) + DW'(1) < cols_eff);
            end
            default:
            begin
                nb_valid = 1'b0;
            end
        endcase
    end

    assign status.nb_valid    = nb_valid;
    assign status.grid_ok     = (rows_eff != '0) && (cols_eff != '0);
    assign status.load_last   = ld_row_last && ld_col_last;
    assign status.sweep_last  = sw_row_last && sw_col_last;
    assign status.best_zero   = (best_rd_reg == '0);
    assign status.dir_done    = (dir_reg == DIR_END);
    assign status.stack_empty = (sp_reg == '0);
    assign status.out_busy    = out_valid_reg;

    assign fin_depth = max_reg + LW'(1);
    assign push = (cell_rd_reg > cur_val_reg) && (best_rd_reg == '0)
               && (sp_reg < SPW'(CELLS - 1));
    assign {pop_row, pop_col, pop_dir, pop_max, pop_val} = stack_rd_reg;

    // Memories with registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            cell_mem[addr_of(ld_row_reg, ld_col_reg)] <= in_cell;
        end
        if (cmd.scan_rd)
        begin
            cell_rd_reg <= cell_mem[addr_of(sw_row_reg, sw_col_reg)];
            best_rd_reg <= best_mem[addr_of(sw_row_reg, sw_col_reg)];
        end
        else if (cmd.nb_rd)
        begin
            cell_rd_reg <= cell_mem[addr_of(nb_row, nb_col)];
            best_rd_reg <= best_mem[addr_of(nb_row, nb_col)];
        end
        if (cmd.clr_step)
        begin
            best_mem[addr_of(sw_row_reg, sw_col_reg)] <= '0;
        end
        else if (cmd.fin)
        begin
            best_mem[addr_of(cur_row_reg, cur_col_reg)] <= fin_depth;
        end
        if (cmd.nb_eval && push)
        begin
            stack_mem[sp_reg[AW-1:0]] <= {cur_row_reg, cur_col_reg, dir_reg + 3'd1,
                                          max_reg, cur_val_reg};
        end
        if (cmd.fin && !status.stack_empty)
        begin
            stack_rd_reg <= stack_mem[AW'(sp_reg - SPW'(1))];
        end
    end

    // Load position and sweep position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_row_reg <= '0;
            ld_col_reg <= '0;
            sw_row_reg <= '0;
            sw_col_reg <= '0;
        end
        else
        begin
            if (cfg_dim_wr || cmd.load_clr || (cmd.load_wr && status.load_last))
            begin
                ld_row_reg <= '0;
                ld_col_reg <= '0;
            end
            else if (cmd.load_wr)
            begin
                if (ld_col_last)
                begin
                    ld_col_reg <= '0;
                    ld_row_reg <= ld_row_reg + CW'(1);
                end
                else
                begin
                    ld_col_reg <= ld_col_reg + CW'(1);
                end
            end
            if (cmd.sweep_clr)
            begin
                sw_row_reg <= '0;
                sw_col_reg <= '0;
            end
            else if (cmd.clr_step || cmd.scan_next)
            begin
                if (sw_col_last)
                begin
                    sw_col_reg <= '0;
                    sw_row_reg <= sw_row_reg + CW'(1);
                end
                else
                begin
                    sw_col_reg <= sw_col_reg + CW'(1);
                end
            end
        end
    end

    // Search top-of-stack registers and stack pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg      <= '0;
            dir_reg     <= DIR_UP;
            ans_reg     <= '0;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            cur_val_reg <= '0;
            nb_row_reg  <= '0;
            nb_col_reg  <= '0;
            max_reg     <= '0;
            d_reg       <= '0;
        end
        else
        begin
            if (cmd.root)
            begin
                cur_row_reg <= sw_row_reg;
                cur_col_reg <= sw_col_reg;
                cur_val_reg <= cell_rd_reg;
                dir_reg     <= DIR_UP;
                max_reg     <= '0;
                sp_reg      <= '0;
            end
            if (cmd.nb_rd)
            begin
                nb_row_reg <= nb_row;
                nb_col_reg <= nb_col;
            end
            if (cmd.dir_inc)
            begin
                dir_reg <= dir_reg + 3'd1;
            end
            if (cmd.nb_eval)
            begin
                if (push)
                begin
                    sp_reg      <= sp_reg + SPW'(1);
                    cur_row_reg <= nb_row_reg;
                    cur_col_reg <= nb_col_reg;
                    cur_val_reg <= cell_rd_reg;
                    dir_reg     <= DIR_UP;
                    max_reg     <= '0;
                end
                else
                begin
                    dir_reg <= dir_reg + 3'd1;
                    if ((cell_rd_reg > cur_val_reg) && (best_rd_reg > max_reg))
                    begin
                        max_reg <= best_rd_reg;
                    end
                end
            end
            if (cmd.fin)
            begin
                d_reg <= fin_depth;
                if (fin_depth > ans_reg)
                begin
                    ans_reg <= fin_depth;
                end
            end
            if (cmd.pop)
            begin
                sp_reg      <= sp_reg - SPW'(1);
                cur_row_reg <= pop_row;
                cur_col_reg <= pop_col;
                cur_val_reg <= pop_val;
                dir_reg     <= pop_dir;
                max_reg     <= (d_reg > pop_max) ? d_reg : pop_max;
            end
            if (cmd.ans_clr)
            begin
                ans_reg <= '0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_path_reg <= PATH_W'(ans_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_path  = out_path_reg;

endmodule
`default_nettype wire
